FILE: rtl/sacn_pkg.sv
`timescale 1ns / 1ps

package sacn_pkg;

   // Fixed field and register widths.
   localparam int ADDR_W      = 32;
   localparam int AW_REG_W    = 6;
   localparam int OFF_REG_W   = 5;
   localparam int IDX_REG_W   = 4;
   localparam int WAYS_REG_W  = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 6;
   localparam int WAY_OUT_W   = 3;
   localparam int SET_OUT_W   = 8;
   localparam int MISS_W      = 32;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;

   // Default geometry.
   localparam int MAX_SETS_DEF = 256;
   localparam int MAX_WAYS_DEF = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDRESS_WIDTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_BITS   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INDEX_BITS    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAYS_IN_USE   = 2'd3;

   // Register reset values.
   localparam logic [AW_REG_W-1:0]   AW_RESET   = 6'd32;
   localparam logic [OFF_REG_W-1:0]  OFF_RESET  = 5'd4;
   localparam logic [IDX_REG_W-1:0]  IDX_RESET  = 4'd8;
   localparam logic [WAYS_REG_W-1:0] WAYS_RESET = 4'd4;

   // Controller to datapath.
   typedef struct packed {
      logic clear;   // write one metadata row of the reset sweep
      logic accept;  // capture an item and read its set
      logic commit;  // write back the set and load the result
   } sacn_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done;  // the sweep is at its last row
   } sacn_sts_type;

endpackage

FILE: rtl/sacn_ctrl.sv
`timescale 1ns / 1ps

module sacn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output sacn_pkg::sacn_cmd_type cmd,
   input  sacn_pkg::sacn_sts_type sts
);
   import sacn_pkg::*;

   localparam logic [1:0] ST_INIT   = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // The result register must be free, or emptied at this edge.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
      rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/sacn_datapath.sv
`timescale 1ns / 1ps

module sacn_datapath #(
   parameter int MAX_SETS = sacn_pkg::MAX_SETS_DEF,
   parameter int MAX_WAYS = sacn_pkg::MAX_WAYS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [sacn_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [sacn_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [sacn_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic [sacn_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  sacn_pkg::sacn_cmd_type               cmd,
   output sacn_pkg::sacn_sts_type               sts
);
   import sacn_pkg::*;

   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int MIB   = $clog2(MAX_SETS + 1) - 1;
   localparam logic [IDX_REG_W-1:0] MIB_V = IDX_REG_W'(MIB);
   localparam int PAD_W = RSP_TDATA_W - MISS_W - SET_OUT_W - WAY_OUT_W - 1;

   // Configuration registers.
   logic [AW_REG_W-1:0]   aw_ff;
   logic [OFF_REG_W-1:0]  off_ff;
   logic [IDX_REG_W-1:0]  ib_ff;
   logic [WAYS_REG_W-1:0] ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff   <= AW_RESET;
         off_ff  <= OFF_RESET;
         ib_ff   <= IDX_RESET;
         ways_ff <= WAYS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ADDRESS_WIDTH: aw_ff   <= csr_wdata[AW_REG_W-1:0];
            CSR_OFFSET_BITS:   off_ff  <= csr_wdata[OFF_REG_W-1:0];
            CSR_INDEX_BITS:    ib_ff   <= csr_wdata[IDX_REG_W-1:0];
            CSR_WAYS_IN_USE:   ways_ff <= csr_wdata[WAYS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Address split.
   logic [ADDR_W-1:0]    addr_mask;
   logic [ADDR_W-1:0]    addr_m;
   logic [ADDR_W-1:0]    set_sh;
   logic [IDX_REG_W-1:0] ib_eff;
   logic [SET_W-1:0]     set_mask;
   logic [SET_W-1:0]     set_in;
   logic [5:0]           tag_amt;
   logic [ADDR_W-1:0]    tag_in;

   always_comb begin
      // A width of zero keeps bit zero; a width beyond the bus keeps all bits.
      for (int i = 0; i < ADDR_W; i++) begin
         addr_mask[i] = (i == 0) || (AW_REG_W'(i) < aw_ff);
      end
      addr_m = req_tdata & addr_mask;
      ib_eff = (ib_ff > MIB_V) ? MIB_V : ib_ff;
      set_sh = addr_m >> off_ff;
      for (int i = 0; i < SET_W; i++) begin
         set_mask[i] = (IDX_REG_W'(i) < ib_eff);
      end
      set_in  = set_sh[SET_W-1:0] & set_mask;
      tag_amt = 6'(off_ff) + 6'(ib_eff);
      tag_in  = addr_m >> tag_amt;
   end

   logic [SET_W-1:0]  set_ff;
   logic [ADDR_W-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
   end

   // Tag memories, one per way.
   logic [ADDR_W-1:0]   tag_rd [MAX_WAYS];
   logic [MAX_WAYS-1:0] tag_we;

   for (genvar k = 0; k < MAX_WAYS; k++) begin : g_way
      logic [ADDR_W-1:0] tag_mem [MAX_SETS];
      logic [ADDR_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (tag_we[k]) begin
            tag_mem[set_ff] <= tag_ff;
         end
         if (cmd.accept) begin
            rd_ff <= tag_mem[set_in];
         end
      end

      assign tag_rd[k] = rd_ff;
   end

   // Metadata memory: NRU bits above valid bits, one row per set.
   logic [2*MAX_WAYS-1:0] meta_mem [MAX_SETS];
   logic [2*MAX_WAYS-1:0] meta_rd_ff;
   logic [2*MAX_WAYS-1:0] meta_wd;
   logic [SET_W-1:0]      meta_wa;
   logic                  meta_we;
   logic [SET_W-1:0]      clr_idx_ff;

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (cmd.accept) begin
         meta_rd_ff <= meta_mem[set_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   assign sts.clear_done = (clr_idx_ff == SET_W'(MAX_SETS - 1));

   // Lookup and replacement.
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] valid_rd;
   logic [MAX_WAYS-1:0] nru_rd;
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] nru_avail;
   logic [MAX_WAYS-1:0] way_oh;
   logic [MAX_WAYS-1:0] nru_base;
   logic [MAX_WAYS-1:0] nru_new;
   logic [MAX_WAYS-1:0] valid_new;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    nru_way;
   logic [WAY_W-1:0]    use_way;
   logic                hit;
   logic                found;
   logic [MISS_W-1:0]   miss_ff;
   logic [MISS_W-1:0]   miss_in;

   always_comb begin
      valid_rd  = meta_rd_ff[MAX_WAYS-1:0];
      nru_rd    = meta_rd_ff[2*MAX_WAYS-1:MAX_WAYS];
      hit_way   = '0;
      nru_way   = '0;
      for (int k = 0; k < MAX_WAYS; k++) begin
         in_use[k]    = (k == 0) || (WAYS_REG_W'(k) < ways_ff);
         hit_vec[k]   = in_use[k] & valid_rd[k] & (tag_rd[k] == tag_ff);
         nru_avail[k] = in_use[k] & nru_rd[k];
      end
      // Lowest-numbered way wins in both searches.
      for (int k = MAX_WAYS - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            hit_way = WAY_W'(k);
         end
         if (nru_avail[k]) begin
            nru_way = WAY_W'(k);
         end
      end
      hit     = |hit_vec;
      found   = |nru_avail;
      use_way = hit ? hit_way : (found ? nru_way : '0);
      for (int k = 0; k < MAX_WAYS; k++) begin
         way_oh[k] = (WAY_W'(k) == use_way);
      end
      // On a miss with no NRU bit left, the whole set in use is marked again.
      nru_base  = (hit || found) ? nru_rd : (nru_rd | in_use);
      nru_new   = nru_base & ~way_oh;
      valid_new = hit ? valid_rd : (valid_rd | way_oh);
      tag_we    = (cmd.commit && !hit) ? way_oh : '0;
      miss_in   = (!hit && (miss_ff != '1)) ? miss_ff + 1'b1 : miss_ff;

      meta_we = cmd.clear | cmd.commit;
      meta_wa = cmd.clear ? clr_idx_ff : set_ff;
      meta_wd = cmd.clear ? {{MAX_WAYS{1'b1}}, {MAX_WAYS{1'b0}}} : {nru_new, valid_new};
   end

   // Result registers. The miss counter changes only at a commit, which
   // happens only once the previous result has left, so it serves directly.
   logic                 hit_ff;
   logic [WAY_OUT_W-1:0] way_ff;
   logic [SET_OUT_W-1:0] set_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ff <= '0;
      end else if (cmd.commit) begin
         miss_ff <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff     <= hit;
         way_ff     <= WAY_OUT_W'(use_way);
         set_out_ff <= SET_OUT_W'(set_ff);
      end
   end

   assign rsp_tdata = {{PAD_W{1'b0}}, miss_ff, set_out_ff, way_ff, hit_ff};

endmodule

FILE: rtl/set_assoc_cache_nru_tags_top.sv
`timescale 1ns / 1ps

// Tag store of a set-associative cache with not-recently-used replacement.
// Each item on the req_ channel carries one address. The block splits it into
// tag, set index and offset under the csr_ registers, looks the tag up in the
// selected set, updates the NRU bits and, on a miss, fills a way. The rsp_
// channel returns one item per request: hit flag, way, set index and the
// saturating miss count including this reference.
// Each item is handled in turn: the address is captured and the set read from
// the tag and metadata memories, then all ways are compared and the set is
// written back. The controller takes no new item until the previous one has
// been written back.
// After reset the block sweeps the metadata memory, one set per cycle, over all
// MAX_SETS sets; req_tready stays low during that sweep, while csr_ writes
// are taken at any time. A finished result waits in an output register; the
// next item is still accepted, and its write-back waits until the earlier
// result is taken, so a stalled receiver holds the block after one item.
// The user must write configuration only while no item is in flight; the block does not enforce it.

module set_assoc_cache_nru_tags_top #(
   parameter int MAX_SETS = sacn_pkg::MAX_SETS_DEF,
   parameter int MAX_WAYS = sacn_pkg::MAX_WAYS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration write port.
   input  logic                             csr_we,
   input  logic [sacn_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [sacn_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sacn_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] address
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] hit, [3:1] way, [11:4] set_index, [43:12] miss_total, [47:44] zero
   output logic [sacn_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import sacn_pkg::*;

   sacn_cmd_type cmd;
   sacn_sts_type sts;

   sacn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   sacn_datapath #(
      .MAX_SETS (MAX_SETS),
      .MAX_WAYS (MAX_WAYS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
